[rtl/assert_macros.svh]
// Assertion helpers for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ppgs_pkg.sv]
package ppgs_pkg;

    localparam int SLOT_W     = 5;
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int DT_W       = 16;
    localparam int LIFE_CFG_W = 31;
    localparam int CFG_IDX_W  = 2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ACK  = 2'd0;
    localparam kind_t KIND_LIVE = 2'd1;
    localparam kind_t KIND_NONE = 2'd2;

    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GRAVITY  = 2'd0;
    localparam cfg_idx_t CFG_LIFETIME = 2'd1;

    localparam logic signed [DATA_W-1:0]   GRAVITY_RESET  = 32'sd642252;
    localparam logic [LIFE_CFG_W-1:0]      LIFETIME_RESET = 31'd6553600;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_TICK_START,
        ST_READ,
        ST_VEL,
        ST_MUL,
        ST_WB,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
        logic [SIZE_W-1:0]        psize;
        logic [DATA_W-1:0]        life;
    } slot_entry_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     accepted;
        logic                     pool;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic [SIZE_W-1:0]        rsize;
        logic                     last;
    } result_t;

    typedef struct packed {
        logic idle;
        logic capture;
        logic create_en;
        logic gdt_load;
        logic walk_clear;
        logic walk_inc;
        logic rd_en;
        logic vel_load;
        logic my_load;
        logic wb_en;
        logic flush_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic new_tick;
        logic slot_live;
        logic walk_last;
        logic expired;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W:0] ext33(input logic signed [DATA_W-1:0] a);
        return {a[DATA_W-1], a};
    endfunction

    // Multiplies by the unsigned time step and floors the Q16 fraction away.
    function automatic logic signed [DATA_W-1:0] mul_dt(input logic signed [DATA_W-1:0] a,
                                                       input logic [DT_W-1:0] dt);
        logic signed [48:0] p;
        p = 49'(a) * $signed({33'd0, dt});
        return p[47:16];
    endfunction

endpackage

[rtl/ppgs_ctrl.sv]
module ppgs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  ppgs_pkg::dp_status_t   sts,
    output ppgs_pkg::ctrl_cmd_t    cmd
);

    ppgs_pkg::state_t state_reg;
    ppgs_pkg::state_t state_next;
    logic             wb_go;

    assign wb_go = sts.expired || !sts.pend_valid || sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppgs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppgs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.new_tick ? ppgs_pkg::ST_TICK_START : ppgs_pkg::ST_CREATE;
                end
            end
            ppgs_pkg::ST_CREATE:
            begin
                if (sts.out_free)
                begin
                    state_next = ppgs_pkg::ST_IDLE;
                end
            end
            ppgs_pkg::ST_TICK_START:
            begin
                state_next = ppgs_pkg::ST_READ;
            end
            ppgs_pkg::ST_READ:
            begin
                if (sts.slot_live)
                begin
                    state_next = ppgs_pkg::ST_VEL;
                end
                else if (sts.walk_last)
                begin
                    state_next = ppgs_pkg::ST_FLUSH;
                end
            end
            ppgs_pkg::ST_VEL:
            begin
                state_next = ppgs_pkg::ST_MUL;
            end
            ppgs_pkg::ST_MUL:
            begin
                state_next = ppgs_pkg::ST_WB;
            end
            ppgs_pkg::ST_WB:
            begin
                if (wb_go)
                begin
                    state_next = sts.walk_last ? ppgs_pkg::ST_FLUSH : ppgs_pkg::ST_READ;
                end
            end
            ppgs_pkg::ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ppgs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ppgs_pkg::ST_IDLE:
            begin
                cmd.idle    = 1'b1;
                cmd.capture = in_valid;
            end
            ppgs_pkg::ST_CREATE:
            begin
                cmd.create_en = sts.out_free;
            end
            ppgs_pkg::ST_TICK_START:
            begin
                cmd.gdt_load   = 1'b1;
                cmd.walk_clear = 1'b1;
            end
            ppgs_pkg::ST_READ:
            begin
                if (sts.slot_live)
                begin
                    cmd.rd_en = 1'b1;
                end
                else if (!sts.walk_last)
                begin
                    cmd.walk_inc = 1'b1;
                end
            end
            ppgs_pkg::ST_VEL:
            begin
                cmd.vel_load = 1'b1;
            end
            ppgs_pkg::ST_MUL:
            begin
                cmd.my_load = 1'b1;
            end
            ppgs_pkg::ST_WB:
            begin
                if (wb_go)
                begin
                    cmd.wb_en    = 1'b1;
                    cmd.walk_inc = !sts.walk_last;
                end
            end
            ppgs_pkg::ST_FLUSH:
            begin
                cmd.flush_en = sts.out_free;
            end
        endcase
    end

endmodule

[rtl/ppgs_dp.sv]
module ppgs_dp #(
    parameter int SLOTS_PER_TEAM = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ppgs_pkg::ctrl_cmd_t                       cmd,
    output ppgs_pkg::dp_status_t                      sts,
    input  logic                                      command,
    input  logic                                      team,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        start_x,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        start_y,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        start_z,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        speed_x,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        speed_y,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        speed_z,
    input  logic [ppgs_pkg::SIZE_W-1:0]               size,
    input  logic [ppgs_pkg::DT_W-1:0]                 time_step,
    input  logic signed [ppgs_pkg::DATA_W-1:0]        gravity,
    input  logic [ppgs_pkg::LIFE_CFG_W-1:0]           lifetime,
    input  logic                                      out_stall,
    output logic                                      out_valid,
    output ppgs_pkg::result_t                         res
);

    localparam int TOTAL = 2 * SLOTS_PER_TEAM;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(TOTAL - 1);
    localparam logic [AW-1:0] TEAM1_BASE = AW'(SLOTS_PER_TEAM);

    logic                                team_reg;
    logic signed [ppgs_pkg::DATA_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic signed [ppgs_pkg::DATA_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic [ppgs_pkg::SIZE_W-1:0]         size_reg;
    logic [ppgs_pkg::DT_W-1:0]           dt_reg;

    logic [TOTAL-1:0]                    live_reg;
    ppgs_pkg::slot_entry_t               mem [TOTAL];
    ppgs_pkg::slot_entry_t               rd_reg;
    logic [AW-1:0]                       addr_reg;
    logic signed [ppgs_pkg::DATA_W-1:0]  gdt_reg;
    logic signed [ppgs_pkg::DATA_W-1:0]  vy_new_reg;
    logic signed [ppgs_pkg::DATA_W-1:0]  mx_reg, my_reg, mz_reg;
    ppgs_pkg::result_t                   pend_reg;
    logic                                pend_valid_reg;
    ppgs_pkg::result_t                   out_reg;
    logic                                out_valid_reg;

    logic [SLOTS_PER_TEAM-1:0]           live_team;
    logic                                free_found;
    logic [ppgs_pkg::SLOT_W-1:0]         free_slot;
    logic [AW-1:0]                       create_addr;
    logic                                walk_team;
    logic [ppgs_pkg::SLOT_W-1:0]         walk_slot;
    logic [ppgs_pkg::DATA_W:0]           life_d;
    logic                                expired;
    ppgs_pkg::slot_entry_t               new_entry;
    ppgs_pkg::slot_entry_t               create_entry;
    ppgs_pkg::result_t                   report;
    ppgs_pkg::result_t                   ack;
    ppgs_pkg::result_t                   none_res;
    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    ppgs_pkg::slot_entry_t               wr_data;
    logic                                out_free;
    logic                                push_pend;
    logic                                out_load;
    ppgs_pkg::result_t                   out_load_val;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            team_reg <= team;
            sx_reg   <= start_x;
            sy_reg   <= start_y;
            sz_reg   <= start_z;
            vx_reg   <= speed_x;
            vy_reg   <= speed_y;
            vz_reg   <= speed_z;
            size_reg <= size;
            dt_reg   <= time_step;
        end
    end

    // The lowest free slot of the requested team wins.
    assign live_team = team_reg ? live_reg[TOTAL-1:SLOTS_PER_TEAM]
                                : live_reg[SLOTS_PER_TEAM-1:0];

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOTS_PER_TEAM - 1; s >= 0; s--)
        begin
            if (!live_team[s])
            begin
                free_found = 1'b1;
                free_slot  = ppgs_pkg::SLOT_W'(s);
            end
        end
    end

    assign create_addr = (team_reg ? TEAM1_BASE : '0) + AW'(free_slot);
    assign walk_team   = (addr_reg >= TEAM1_BASE);
    assign walk_slot   = ppgs_pkg::SLOT_W'(walk_team ? addr_reg - TEAM1_BASE : addr_reg);

    assign life_d  = {rd_reg.life[ppgs_pkg::DATA_W-1], rd_reg.life} - {17'd0, dt_reg};
    assign expired = life_d[ppgs_pkg::DATA_W];

    always_comb
    begin
        new_entry.px    = ppgs_pkg::sat33(ppgs_pkg::ext33(rd_reg.px) + ppgs_pkg::ext33(mx_reg));
        new_entry.py    = ppgs_pkg::sat33(ppgs_pkg::ext33(rd_reg.py) + ppgs_pkg::ext33(my_reg));
        new_entry.pz    = ppgs_pkg::sat33(ppgs_pkg::ext33(rd_reg.pz) + ppgs_pkg::ext33(mz_reg));
        new_entry.vx    = rd_reg.vx;
        new_entry.vy    = vy_new_reg;
        new_entry.vz    = rd_reg.vz;
        new_entry.psize = rd_reg.psize;
        new_entry.life  = life_d[ppgs_pkg::DATA_W-1:0];

        create_entry.px    = sx_reg;
        create_entry.py    = sy_reg;
        create_entry.pz    = sz_reg;
        create_entry.vx    = vx_reg;
        create_entry.vy    = vy_reg;
        create_entry.vz    = vz_reg;
        create_entry.psize = size_reg;
        create_entry.life  = {1'b0, lifetime};

        report.kind     = ppgs_pkg::KIND_LIVE;
        report.accepted = 1'b0;
        report.pool     = walk_team;
        report.slot     = walk_slot;
        report.x        = new_entry.px;
        report.y        = new_entry.py;
        report.z        = new_entry.pz;
        report.rsize    = rd_reg.psize;
        report.last     = 1'b0;

        ack.kind     = ppgs_pkg::KIND_ACK;
        ack.accepted = free_found;
        ack.pool     = team_reg;
        ack.slot     = free_found ? free_slot : '0;
        ack.x        = free_found ? sx_reg : '0;
        ack.y        = free_found ? sy_reg : '0;
        ack.z        = free_found ? sz_reg : '0;
        ack.rsize    = free_found ? size_reg : '0;
        ack.last     = 1'b1;

        none_res      = '0;
        none_res.kind = ppgs_pkg::KIND_NONE;
        none_res.last = 1'b1;
    end

    assign wr_en   = (cmd.create_en && free_found) || cmd.wb_en;
    assign wr_addr = cmd.create_en ? create_addr : addr_reg;
    assign wr_data = cmd.create_en ? create_entry : new_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gdt_load)
        begin
            gdt_reg <= ppgs_pkg::mul_dt(gravity, dt_reg);
        end
        if (cmd.vel_load)
        begin
            vy_new_reg <= ppgs_pkg::sat33(ppgs_pkg::ext33(rd_reg.vy) - ppgs_pkg::ext33(gdt_reg));
            mx_reg     <= ppgs_pkg::mul_dt(rd_reg.vx, dt_reg);
            mz_reg     <= ppgs_pkg::mul_dt(rd_reg.vz, dt_reg);
        end
        if (cmd.my_load)
        begin
            my_reg <= ppgs_pkg::mul_dt(vy_new_reg, dt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (cmd.create_en && free_found)
        begin
            live_reg[create_addr] <= 1'b1;
        end
        else if (cmd.wb_en && expired)
        begin
            live_reg[addr_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.walk_clear)
        begin
            addr_reg <= '0;
        end
        else if (cmd.walk_inc)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    // A report is held back one slot so that the final one can carry last.
    assign push_pend = cmd.wb_en && !expired && pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.walk_clear || cmd.flush_en)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.wb_en && !expired)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wb_en && !expired)
        begin
            pend_reg <= report;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = cmd.create_en || cmd.flush_en || push_pend;

    always_comb
    begin
        out_load_val = pend_reg;
        if (cmd.create_en)
        begin
            out_load_val = ack;
        end
        else if (cmd.flush_en)
        begin
            out_load_val      = pend_valid_reg ? pend_reg : none_res;
            out_load_val.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_load_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    assign sts.new_tick   = (command == ppgs_pkg::CMD_TICK);
    assign sts.slot_live  = live_reg[addr_reg];
    assign sts.walk_last  = (addr_reg == LAST_ADDR);
    assign sts.expired    = expired;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

endmodule

[rtl/projectile_pool_gravity_step.sv]
// Channel   Beat carries                                    Handshake
// input     command, team, start_*, speed_*, size, time_step in_valid / in_stall
// output    kind, accepted, pool, slot, now_*, report_size   out_valid / out_stall
// config    cfg_index, cfg_data                              cfg_en
//
// A create captures its beat, searches for a free slot and registers its ack once the output is free,
// then returns to idle to take the next beat.
// A tick walks all 2*SLOTS_PER_TEAM slots: a free slot passes through READ alone and a live one
// through READ, VEL, MUL and WB (memory read, velocity and x/z multiply, y multiply, write-back),
// with the walk setup before the walk and the final flush and the idle state after it.
// Reset clears every live flag and loads the register defaults; the slot memory is not cleared.
// A stalled output holds the walk at the next report until the held beat is taken.
`include "assert_macros.svh"

module projectile_pool_gravity_step #(
    parameter int SLOTS_PER_TEAM = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 command,
    input  logic                                 team,
    input  logic signed [ppgs_pkg::DATA_W-1:0]   start_x,
    input  logic signed [ppgs_pkg::DATA_W-1:0]   start_y,
    input  logic signed [ppgs_pkg::DATA_W-1:0]   start_z,
    input  logic signed [ppgs_pkg::DATA_W-1:0]   speed_x,
    input  logic signed [ppgs_pkg::DATA_W-1:0]   speed_y,
    input  logic signed [ppgs_pkg::DATA_W-1:0]   speed_z,
    input  logic [ppgs_pkg::SIZE_W-1:0]          size,
    input  logic [ppgs_pkg::DT_W-1:0]            time_step,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           kind,
    output logic                                 accepted,
    output logic                                 pool,
    output logic [ppgs_pkg::SLOT_W-1:0]          slot,
    output logic signed [ppgs_pkg::DATA_W-1:0]   now_x,
    output logic signed [ppgs_pkg::DATA_W-1:0]   now_y,
    output logic signed [ppgs_pkg::DATA_W-1:0]   now_z,
    output logic [ppgs_pkg::SIZE_W-1:0]          report_size,
    output logic                                 last,
    input  logic                                 cfg_en,
    input  logic [ppgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppgs_pkg::DATA_W-1:0]          cfg_data
);

    logic signed [ppgs_pkg::DATA_W-1:0]  gravity_reg;
    logic [ppgs_pkg::LIFE_CFG_W-1:0]     lifetime_reg;
    ppgs_pkg::ctrl_cmd_t                 cmd;
    ppgs_pkg::dp_status_t                sts;
    ppgs_pkg::result_t                   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= ppgs_pkg::GRAVITY_RESET;
            lifetime_reg <= ppgs_pkg::LIFETIME_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                ppgs_pkg::CFG_GRAVITY:
                begin
                    gravity_reg <= cfg_data;
                end
                ppgs_pkg::CFG_LIFETIME:
                begin
                    lifetime_reg <= cfg_data[ppgs_pkg::LIFE_CFG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    ppgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppgs_dp #(
        .SLOTS_PER_TEAM (SLOTS_PER_TEAM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .command   (command),
        .team      (team),
        .start_x   (start_x),
        .start_y   (start_y),
        .start_z   (start_z),
        .speed_x   (speed_x),
        .speed_y   (speed_y),
        .speed_z   (speed_z),
        .size      (size),
        .time_step (time_step),
        .gravity   (gravity_reg),
        .lifetime  (lifetime_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res)
    );

    assign in_stall    = !cmd.idle;
    assign kind        = res.kind;
    assign accepted    = res.accepted;
    assign pool        = res.pool;
    assign slot        = res.slot;
    assign now_x       = res.x;
    assign now_y       = res.y;
    assign now_z       = res.z;
    assign report_size = res.rsize;
    assign last        = res.last;

    `ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
    `ASSERT_SAME(a_ack_is_last, clk, rst_n, out_valid && (kind == ppgs_pkg::KIND_ACK), last, "create ack without last")
    `ASSERT_SAME(a_none_is_last, clk, rst_n, out_valid && (kind == ppgs_pkg::KIND_NONE), last, "empty report without last")
    `ASSERT_SAME(a_accept_only_ack, clk, rst_n, out_valid && accepted, kind == ppgs_pkg::KIND_ACK, "accepted flag on a report")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS = 32;
    localparam int TOTAL = 2 * SLOTS;
    localparam int SETTLE_CYCLES = 320;
    localparam int QUIET_LIMIT = 20000;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam ppgs_pkg::cfg_idx_t CFG_SPARE_A = 2'd2;
    localparam ppgs_pkg::cfg_idx_t CFG_SPARE_B = 2'd3;

    typedef struct {
        logic                               command;
        logic                               team;
        logic signed [ppgs_pkg::DATA_W-1:0] sx;
        logic signed [ppgs_pkg::DATA_W-1:0] sy;
        logic signed [ppgs_pkg::DATA_W-1:0] sz;
        logic signed [ppgs_pkg::DATA_W-1:0] vx;
        logic signed [ppgs_pkg::DATA_W-1:0] vy;
        logic signed [ppgs_pkg::DATA_W-1:0] vz;
        logic [ppgs_pkg::SIZE_W-1:0]        psize;
        logic [ppgs_pkg::DT_W-1:0]          dt;
        bit                                 drain_first;
    } shot_item_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               command = 1'b0;
    logic                               team = 1'b0;
    logic signed [ppgs_pkg::DATA_W-1:0] start_x = '0;
    logic signed [ppgs_pkg::DATA_W-1:0] start_y = '0;
    logic signed [ppgs_pkg::DATA_W-1:0] start_z = '0;
    logic signed [ppgs_pkg::DATA_W-1:0] speed_x = '0;
    logic signed [ppgs_pkg::DATA_W-1:0] speed_y = '0;
    logic signed [ppgs_pkg::DATA_W-1:0] speed_z = '0;
    logic [ppgs_pkg::SIZE_W-1:0]        size = '0;
    logic [ppgs_pkg::DT_W-1:0]          time_step = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [1:0]                         kind;
    logic                               accepted;
    logic                               pool;
    logic [ppgs_pkg::SLOT_W-1:0]        slot;
    logic signed [ppgs_pkg::DATA_W-1:0] now_x;
    logic signed [ppgs_pkg::DATA_W-1:0] now_y;
    logic signed [ppgs_pkg::DATA_W-1:0] now_z;
    logic [ppgs_pkg::SIZE_W-1:0]        report_size;
    logic                               last;
    logic                               cfg_en = 1'b0;
    logic [ppgs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [ppgs_pkg::DATA_W-1:0]        cfg_data = '0;

    shot_item_t        shots_pending[$];
    shot_item_t        shot_cur;
    ppgs_pkg::result_t due_results[$];
    ppgs_pkg::result_t beat_want;
    int                fail_count = 0;
    int                quiet_cycles = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    bit                          slot_live[TOTAL];
    int                          slot_px[TOTAL];
    int                          slot_py[TOTAL];
    int                          slot_pz[TOTAL];
    int                          slot_vx[TOTAL];
    int                          slot_vy[TOTAL];
    int                          slot_vz[TOTAL];
    logic [ppgs_pkg::SIZE_W-1:0] slot_size[TOTAL];
    int                          slot_life[TOTAL];
    longint                      grav_cfg = longint'(ppgs_pkg::GRAVITY_RESET);
    int                          life_cfg = int'({1'b0, ppgs_pkg::LIFETIME_RESET});

    projectile_pool_gravity_step #(
        .SLOTS_PER_TEAM(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .team(team),
        .start_x(start_x),
        .start_y(start_y),
        .start_z(start_z),
        .speed_x(speed_x),
        .speed_y(speed_y),
        .speed_z(speed_z),
        .size(size),
        .time_step(time_step),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .accepted(accepted),
        .pool(pool),
        .slot(slot),
        .now_x(now_x),
        .now_y(now_y),
        .now_z(now_z),
        .report_size(report_size),
        .last(last),
        .cfg_en(cfg_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int sat32(input longint v);
        if (v > SAT_HI)
        begin
            return int'(SAT_HI);
        end
        if (v < SAT_LO)
        begin
            return int'(SAT_LO);
        end
        return int'(v);
    endfunction

    task automatic pool_step(input shot_item_t it);
        ppgs_pkg::result_t r;
        ppgs_pkg::result_t batch[$];
        int                s;
        int                idx;
        longint            dt;
        bit                placed;
        r = '0;
        placed = 1'b0;
        dt = longint'(it.dt);
        if (it.command == ppgs_pkg::CMD_CREATE)
        begin
            r.kind = ppgs_pkg::KIND_ACK;
            r.pool = it.team;
            for (s = 0; s < SLOTS && !placed; s++)
            begin
                idx = int'(it.team) * SLOTS + s;
                if (!slot_live[idx])
                begin
                    placed = 1'b1;
                    slot_live[idx] = 1'b1;
                    slot_px[idx] = it.sx;
                    slot_py[idx] = it.sy;
                    slot_pz[idx] = it.sz;
                    slot_vx[idx] = it.vx;
                    slot_vy[idx] = it.vy;
                    slot_vz[idx] = it.vz;
                    slot_size[idx] = it.psize;
                    slot_life[idx] = life_cfg;
                    r.accepted = 1'b1;
                    r.slot = ppgs_pkg::SLOT_W'(s);
                    r.x = it.sx;
                    r.y = it.sy;
                    r.z = it.sz;
                    r.rsize = it.psize;
                end
            end
            batch.push_back(r);
        end
        else
        begin
            for (idx = 0; idx < TOTAL; idx++)
            begin
                if (slot_live[idx])
                begin
                    slot_vy[idx] = sat32(longint'(slot_vy[idx]) - ((grav_cfg * dt) >>> 16));
                    slot_px[idx] = sat32(longint'(slot_px[idx])
                                         + ((longint'(slot_vx[idx]) * dt) >>> 16));
                    slot_py[idx] = sat32(longint'(slot_py[idx])
                                         + ((longint'(slot_vy[idx]) * dt) >>> 16));
                    slot_pz[idx] = sat32(longint'(slot_pz[idx])
                                         + ((longint'(slot_vz[idx]) * dt) >>> 16));
                    slot_life[idx] = sat32(longint'(slot_life[idx]) - dt);
                    if (slot_life[idx] < 0)
                    begin
                        slot_live[idx] = 1'b0;
                    end
                    else
                    begin
                        r = '0;
                        r.kind = ppgs_pkg::KIND_LIVE;
                        r.pool = (idx >= SLOTS);
                        r.slot = ppgs_pkg::SLOT_W'(idx % SLOTS);
                        r.x = slot_px[idx];
                        r.y = slot_py[idx];
                        r.z = slot_pz[idx];
                        r.rsize = slot_size[idx];
                        batch.push_back(r);
                    end
                end
            end
            if (batch.size() == 0)
            begin
                r = '0;
                r.kind = ppgs_pkg::KIND_NONE;
                batch.push_back(r);
            end
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
        begin
            due_results.push_back(batch[k]);
        end
    endtask

    function automatic logic [ppgs_pkg::DATA_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic shot_item_t make_item(input logic cmd, input logic tm,
                                             input logic [ppgs_pkg::DT_W-1:0] dt);
        shot_item_t it;
        it.command = cmd;
        it.team = tm;
        it.sx = rand_word();
        it.sy = rand_word();
        it.sz = rand_word();
        it.vx = rand_word();
        it.vy = rand_word();
        it.vz = rand_word();
        it.psize = ppgs_pkg::SIZE_W'($urandom());
        it.dt = dt;
        it.drain_first = 1'b0;
        return it;
    endfunction

    function automatic shot_item_t random_item();
        logic [ppgs_pkg::DT_W-1:0] dt;
        int                        pick;
        shot_item_t                it;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            dt = ppgs_pkg::DT_W'($urandom());
        end
        else if (pick < 85)
        begin
            dt = ppgs_pkg::DT_W'($urandom_range(15));
        end
        else
        begin
            dt = ($urandom_range(1) == 1) ? '1 : '0;
        end
        it = make_item(($urandom_range(99) < 55) ? ppgs_pkg::CMD_CREATE : ppgs_pkg::CMD_TICK,
                       1'($urandom_range(1)), dt);
        it.drain_first = ($urandom_range(99) < 4);
        return it;
    endfunction

    task automatic add_random(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            shots_pending.push_back(random_item());
        end
    endtask

    task automatic write_reg(input ppgs_pkg::cfg_idx_t idx,
                             input logic [ppgs_pkg::DATA_W-1:0] value);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_en <= 1'b0;
        if (idx == ppgs_pkg::CFG_GRAVITY)
        begin
            grav_cfg = longint'($signed(value));
        end
        else if (idx == ppgs_pkg::CFG_LIFETIME)
        begin
            life_cfg = int'({1'b0, value[ppgs_pkg::LIFE_CFG_W-1:0]});
        end
    endtask

    task automatic settle();
        do
        begin
            @(posedge clk);
        end
        while (shots_pending.size() != 0 || in_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [ppgs_pkg::DATA_W-1:0] want,
                               input logic [ppgs_pkg::DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pool_step(shot_cur);
            end
            if (!in_valid || !in_stall)
            begin
                if (shots_pending.size() != 0
                    && !(shots_pending[0].drain_first && due_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    shot_cur = shots_pending.pop_front();
                    in_valid <= 1'b1;
                    command <= shot_cur.command;
                    team <= shot_cur.team;
                    start_x <= shot_cur.sx;
                    start_y <= shot_cur.sy;
                    start_z <= shot_cur.sz;
                    speed_x <= shot_cur.vx;
                    speed_y <= shot_cur.vy;
                    speed_z <= shot_cur.vz;
                    size <= shot_cur.psize;
                    time_step <= shot_cur.dt;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result beat with nothing expected, kind %0d slot %0d", kind, slot);
                fail_count++;
            end
            else
            begin
                beat_want = due_results.pop_front();
                check_field("kind", beat_want.kind, kind);
                check_field("accepted", beat_want.accepted, accepted);
                check_field("pool", beat_want.pool, pool);
                check_field("slot", beat_want.slot, slot);
                check_field("now_x", beat_want.x, now_x);
                check_field("now_y", beat_want.y, now_y);
                check_field("now_z", beat_want.z, now_z);
                check_field("report_size", beat_want.rsize, report_size);
                check_field("last", beat_want.last, last);
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        shot_item_t it;
        logic       fill_team;
        int         n;

        send_idle_pct = 25;
        recv_idle_pct = 77;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b1, 16'h0100));
        it = make_item(ppgs_pkg::CMD_CREATE, 1'b0, 16'hFFFF);
        it.sx = 32'h7FFF_FFFF;
        it.sy = 32'h8000_0000;
        it.sz = 32'h0000_0000;
        it.vx = 32'h7FFF_FFFF;
        it.vy = 32'h8000_0000;
        it.vz = 32'hFFFF_FFFF;
        it.psize = 16'hFFFF;
        shots_pending.push_back(it);
        it = make_item(ppgs_pkg::CMD_CREATE, 1'b1, 16'h0000);
        it.sx = 32'h8000_0000;
        it.sy = 32'h7FFF_FFFF;
        it.sz = 32'hFFFF_FFFF;
        it.vx = 32'h8000_0000;
        it.vy = 32'h7FFF_FFFF;
        it.vz = 32'h0000_0001;
        it.psize = 16'h0000;
        shots_pending.push_back(it);
        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b0, 16'h0000));
        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b1, 16'hFFFF));
        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b0, 16'h0001));
        it = make_item(ppgs_pkg::CMD_CREATE, 1'b0, 16'h8000);
        it.sx = '0;
        it.sy = '0;
        it.sz = '0;
        it.vx = '0;
        it.vy = '0;
        it.vz = '0;
        it.psize = 16'h8000;
        shots_pending.push_back(it);
        shots_pending.push_back(make_item(ppgs_pkg::CMD_CREATE, 1'b1, 16'h7FFF));
        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b1, 16'hFFFF));
        settle();

        // A zero lifetime survives a zero step but expires on any nonzero one.
        write_reg(ppgs_pkg::CFG_GRAVITY, 32'h8000_0000);
        write_reg(ppgs_pkg::CFG_LIFETIME, 32'h0000_0000);
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
        shots_pending.push_back(make_item(ppgs_pkg::CMD_CREATE, 1'b0, 16'h1234));
        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b0, 16'h0000));
        shots_pending.push_back(make_item(ppgs_pkg::CMD_TICK, 1'b1, 16'h0001));
        shots_pending.push_back(make_item(ppgs_pkg::CMD_CREATE, 1'b0, 16'h4321));
        settle();

        write_reg(ppgs_pkg::CFG_GRAVITY, 32'h7FFF_FFFF);
        write_reg(ppgs_pkg::CFG_LIFETIME, 32'h0008_0000);
        fill_team = 1'($urandom_range(1));
        for (n = 0; n < 34; n++)
        begin
            shots_pending.push_back(make_item(ppgs_pkg::CMD_CREATE, fill_team,
                                              ppgs_pkg::DT_W'($urandom())));
        end
        add_random(16);
        settle();

        send_idle_pct = 77;
        recv_idle_pct = 25;
        write_reg(ppgs_pkg::CFG_GRAVITY, $urandom());
        write_reg(ppgs_pkg::CFG_LIFETIME, $urandom_range(32'h0004_0000));
        add_random(30);
        shots_pending[0].drain_first = 1'b1;
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ppgs_pkg::CFG_GRAVITY, 32'h0000_0000);
        write_reg(ppgs_pkg::CFG_LIFETIME, 32'hFFFF_FFFF);
        add_random(30);
        shots_pending[15].drain_first = 1'b1;
        settle();

        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
